// File: hw/rtl/camq_pkg.sv
// Shared types and constants of the cumulative-ack message queue.
package camq_pkg;

	localparam int OP_W    = 3;
	localparam int FROM_W  = 2;
	localparam int LEVEL_W = 5;
	localparam int COUNT_W = 5;
	localparam int LIMIT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ   = 3'd0,
		OP_SEND  = 3'd1,
		OP_ACK   = 3'd2,
		OP_NACK  = 3'd3,
		OP_DRAIN = 3'd4,
		OP_FLUSH = 3'd5
	} op_t;

	typedef enum logic [FROM_W-1:0] {
		Q_SEND = 2'd0,
		Q_SENT = 2'd1,
		Q_DEAD = 2'd2
	} qsel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ,
		ST_SEND_RD,
		ST_SEND_WR,
		ST_SRCH,
		ST_MOVE,
		ST_EMIT_START,
		ST_EMIT,
		ST_RESP
	} state_t;

endpackage

// File: hw/rtl/camq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module camq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/cumulative_ack_message_queue_unit.sv
// Top level of the cumulative-ack message queue: three tag FIFOs under one sequencer.
//
// The block holds three FIFOs of message tags, each QUEUE_DEPTH entries deep: a send
// queue, a sent queue awaiting acknowledgment and a dead queue, each kept in its own
// RAM with a registered read port. A transaction is taken at a rising edge where start
// is high and busy is low; busy then stays high until the last result of that
// transaction has been put on the result ports. Every result is shown for exactly one
// cycle with res_stb high and must be captured then, because the receiver cannot stall
// the block; last marks the final result of a transaction, and the three level ports
// always show the queue levels after the whole transaction. Ack and nack scan the sent
// queue one entry per cycle through its single read port, and nack then moves the
// acknowledged run into the dead queue at one entry per cycle. Drain and flush read one
// tag per cycle, except that flush issues no read when it steps to the next queue. The
// longest transaction is a flush of three full queues. No reset sweep is needed: only
// pointers, levels and control flags are reset, and RAM entries are read only after
// they have been written.
module cumulative_ack_message_queue_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [camq_pkg::OP_W-1:0]    op,
	input  logic [TAG_BITS-1:0]          msg_tag,
	input  logic                         needs_ack,
	input  logic [camq_pkg::LIMIT_W-1:0] drain_limit,
	output logic                         res_stb,
	output logic                         valid_res,
	output logic [TAG_BITS-1:0]          out_tag,
	output logic [camq_pkg::FROM_W-1:0]  from_queue,
	output logic                         found,
	output logic [camq_pkg::COUNT_W-1:0] count,
	output logic                         overflow,
	output logic                         last,
	output logic [camq_pkg::LEVEL_W-1:0] send_level,
	output logic [camq_pkg::LEVEL_W-1:0] sent_level,
	output logic [camq_pkg::LEVEL_W-1:0] dead_level
);

	// Pointer width, level width and a spare bit for slot arithmetic.
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = LW + 1;
	localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

	// Physical slot of the entry off places behind head, wrapped once.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
		input logic [LW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(off);
		if (sum >= SW'(QUEUE_DEPTH)) begin
			sum = sum - SW'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] head);
		return slot(head, LW'(1));
	endfunction

	camq_pkg::state_t state_q, state_d;

	// Queue pointers, indexed by queue code.
	logic [AW-1:0] head_q [3];
	logic [AW-1:0] head_d [3];
	logic [LW-1:0] lvl_q  [3];
	logic [LW-1:0] lvl_d  [3];
	logic [LW-1:0] fin_q  [3];
	logic [LW-1:0] fin_d  [3];

	// Latched transaction.
	camq_pkg::op_t         op_q, op_d;
	logic [TAG_BITS-1:0]   tag_q, tag_d;
	logic                  need_q, need_d;
	logic [camq_pkg::LIMIT_W-1:0] limit_q, limit_d;

	// Single-result fields gathered while the sequencer runs.
	logic                  ovf_q, ovf_d;
	logic                  rvalid_q, rvalid_d;
	logic [TAG_BITS-1:0]   rtag_q, rtag_d;
	camq_pkg::qsel_t       rfrom_q, rfrom_d;
	logic                  found_q, found_d;
	logic [camq_pkg::COUNT_W-1:0] count_q, count_d;

	// Search and move bookkeeping.
	logic [LW-1:0]         idx_q, idx_d;
	logic                  cmp_vld_q, cmp_vld_d;
	logic [LW-1:0]         cmp_idx_q, cmp_idx_d;
	logic [LW-1:0]         run;
	logic [LW-1:0]         mv_cnt_q, mv_cnt_d;
	logic                  mv_vld_q, mv_vld_d;

	// Emission bookkeeping for drain and flush.
	camq_pkg::qsel_t       q_q, q_d;
	camq_pkg::qsel_t       q_next;
	logic [LW-1:0]         em_cnt_q, em_cnt_d;
	logic                  em_vld_q, em_vld_d;
	logic                  em_last_q, em_last_d;
	logic                  em_done_q, em_done_d;
	camq_pkg::qsel_t       em_from_q, em_from_d;
	logic                  is_last;
	logic [camq_pkg::LEVEL_W-1:0] drain_n;
	logic [camq_pkg::LEVEL_W-1:0] dead_ext;

	// Output registers.
	logic                  res_stb_q, res_stb_d;
	logic                  valid_res_q, valid_res_d;
	logic [TAG_BITS-1:0]   out_tag_q, out_tag_d;
	logic [camq_pkg::FROM_W-1:0]  from_queue_q, from_queue_d;
	logic                  found_o_q, found_o_d;
	logic [camq_pkg::COUNT_W-1:0] count_o_q, count_o_d;
	logic                  overflow_q, overflow_d;
	logic                  last_q, last_d;
	logic [camq_pkg::LEVEL_W-1:0] send_lvl_o_q, send_lvl_o_d;
	logic [camq_pkg::LEVEL_W-1:0] sent_lvl_o_q, sent_lvl_o_d;
	logic [camq_pkg::LEVEL_W-1:0] dead_lvl_o_q, dead_lvl_o_d;

	// RAM ports. The send queue keeps the ack-needed flag above the tag.
	logic                  s_we;
	logic [AW-1:0]         s_waddr, s_raddr;
	logic [TAG_BITS:0]     s_wdata, s_rdata;
	logic                  t_we;
	logic [AW-1:0]         t_waddr, t_raddr;
	logic [TAG_BITS-1:0]   t_wdata, t_rdata;
	logic                  d_we;
	logic [AW-1:0]         d_waddr, d_raddr;
	logic [TAG_BITS-1:0]   d_wdata, d_rdata;

	camq_ram #(.WIDTH(TAG_BITS + 1), .DEPTH(QUEUE_DEPTH)) u_send_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	camq_ram #(.WIDTH(TAG_BITS), .DEPTH(QUEUE_DEPTH)) u_sent_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	camq_ram #(.WIDTH(TAG_BITS), .DEPTH(QUEUE_DEPTH)) u_dead_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// Drain emits the whole dead queue when the limit is zero or at or above its level.
	assign dead_ext = camq_pkg::LEVEL_W'(lvl_q[camq_pkg::Q_DEAD]);
	assign drain_n  = (limit_q == '0 || limit_q >= dead_ext) ? dead_ext : limit_q;

	// A hit at compare index i acknowledges i + 1 entries.
	assign run = cmp_idx_q + LW'(1);

	// Flush walks send, sent, dead in that order.
	assign q_next = (q_q == camq_pkg::Q_SEND) ? camq_pkg::Q_SENT : camq_pkg::Q_DEAD;

	// The tag being issued is the final one of the transaction when nothing is left
	// in this queue after it and, for flush, every later queue is empty.
	assign is_last = (em_cnt_q == LW'(1)) &&
		(op_q == camq_pkg::OP_DRAIN || q_q == camq_pkg::Q_DEAD ||
		 (q_q == camq_pkg::Q_SENT && lvl_q[camq_pkg::Q_DEAD] == '0) ||
		 (q_q == camq_pkg::Q_SEND && lvl_q[camq_pkg::Q_SENT] == '0 &&
		  lvl_q[camq_pkg::Q_DEAD] == '0));

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		lvl_d     = lvl_q;
		fin_d     = fin_q;
		op_d      = op_q;
		tag_d     = tag_q;
		need_d    = need_q;
		limit_d   = limit_q;
		ovf_d     = ovf_q;
		rvalid_d  = rvalid_q;
		rtag_d    = rtag_q;
		rfrom_d   = rfrom_q;
		found_d   = found_q;
		count_d   = count_q;
		idx_d     = idx_q;
		cmp_vld_d = cmp_vld_q;
		cmp_idx_d = cmp_idx_q;
		mv_cnt_d  = mv_cnt_q;
		mv_vld_d  = mv_vld_q;
		q_d       = q_q;
		em_cnt_d  = em_cnt_q;
		em_vld_d  = em_vld_q;
		em_last_d = em_last_q;
		em_done_d = em_done_q;
		em_from_d = em_from_q;

		res_stb_d    = 1'b0;
		valid_res_d  = valid_res_q;
		out_tag_d    = out_tag_q;
		from_queue_d = from_queue_q;
		found_o_d    = found_o_q;
		count_o_d    = count_o_q;
		overflow_d   = overflow_q;
		last_d       = last_q;
		send_lvl_o_d = send_lvl_o_q;
		sent_lvl_o_d = sent_lvl_o_q;
		dead_lvl_o_d = dead_lvl_o_q;

		s_we    = 1'b0;
		s_waddr = slot(head_q[camq_pkg::Q_SEND], lvl_q[camq_pkg::Q_SEND]);
		s_wdata = {need_q, tag_q};
		s_raddr = head_q[camq_pkg::Q_SEND];
		t_we    = 1'b0;
		t_waddr = slot(head_q[camq_pkg::Q_SENT], lvl_q[camq_pkg::Q_SENT]);
		t_wdata = s_rdata[TAG_BITS-1:0];
		t_raddr = head_q[camq_pkg::Q_SENT];
		d_we    = 1'b0;
		d_waddr = slot(head_q[camq_pkg::Q_DEAD], lvl_q[camq_pkg::Q_DEAD]);
		d_wdata = t_rdata;
		d_raddr = head_q[camq_pkg::Q_DEAD];

		case (state_q)
			camq_pkg::ST_IDLE: begin
				if (start) begin
					op_d     = camq_pkg::op_t'(op);
					tag_d    = msg_tag;
					need_d   = needs_ack;
					limit_d  = drain_limit;
					ovf_d    = 1'b0;
					rvalid_d = 1'b0;
					rtag_d   = '0;
					rfrom_d  = camq_pkg::Q_SEND;
					found_d  = 1'b0;
					count_d  = '0;
					case (camq_pkg::op_t'(op))
						camq_pkg::OP_ENQ:  state_d = camq_pkg::ST_ENQ;
						camq_pkg::OP_SEND: state_d = camq_pkg::ST_SEND_RD;
						camq_pkg::OP_ACK, camq_pkg::OP_NACK: begin
							idx_d     = '0;
							cmp_vld_d = 1'b0;
							state_d   = camq_pkg::ST_SRCH;
						end
						camq_pkg::OP_DRAIN, camq_pkg::OP_FLUSH: begin
							state_d = camq_pkg::ST_EMIT_START;
						end
						default: state_d = camq_pkg::ST_RESP;
					endcase
				end
			end

			camq_pkg::ST_ENQ: begin
				if (lvl_q[camq_pkg::Q_SEND] < DEPTH_L) begin
					s_we = 1'b1;
					lvl_d[camq_pkg::Q_SEND] = lvl_q[camq_pkg::Q_SEND] + LW'(1);
				end else begin
					ovf_d = 1'b1;
				end
				state_d = camq_pkg::ST_RESP;
			end

			camq_pkg::ST_SEND_RD: begin
				if (lvl_q[camq_pkg::Q_SEND] == '0) begin
					state_d = camq_pkg::ST_RESP;
				end else begin
					state_d = camq_pkg::ST_SEND_WR;
				end
			end

			camq_pkg::ST_SEND_WR: begin
				head_d[camq_pkg::Q_SEND] = inc(head_q[camq_pkg::Q_SEND]);
				lvl_d[camq_pkg::Q_SEND]  = lvl_q[camq_pkg::Q_SEND] - LW'(1);
				rvalid_d = 1'b1;
				rtag_d   = s_rdata[TAG_BITS-1:0];
				rfrom_d  = camq_pkg::Q_SEND;
				if (s_rdata[TAG_BITS]) begin
					if (lvl_q[camq_pkg::Q_SENT] < DEPTH_L) begin
						t_we = 1'b1;
						lvl_d[camq_pkg::Q_SENT] = lvl_q[camq_pkg::Q_SENT] + LW'(1);
					end else begin
						ovf_d = 1'b1;
					end
				end
				state_d = camq_pkg::ST_RESP;
			end

			camq_pkg::ST_SRCH: begin
				// One read is issued per cycle; the entry read last cycle is compared now.
				if (cmp_vld_q && t_rdata == tag_q) begin
					found_d = 1'b1;
					count_d = camq_pkg::COUNT_W'(run);
					if (op_q == camq_pkg::OP_ACK) begin
						head_d[camq_pkg::Q_SENT] = slot(head_q[camq_pkg::Q_SENT], run);
						lvl_d[camq_pkg::Q_SENT]  = lvl_q[camq_pkg::Q_SENT] - run;
						state_d = camq_pkg::ST_RESP;
					end else begin
						mv_cnt_d = run;
						mv_vld_d = 1'b0;
						state_d  = camq_pkg::ST_MOVE;
					end
				end else if (idx_q < lvl_q[camq_pkg::Q_SENT]) begin
					t_raddr   = slot(head_q[camq_pkg::Q_SENT], idx_q);
					cmp_vld_d = 1'b1;
					cmp_idx_d = idx_q;
					idx_d     = idx_q + LW'(1);
				end else begin
					state_d = camq_pkg::ST_RESP;
				end
			end

			camq_pkg::ST_MOVE: begin
				// Pop the sent head while the entry popped last cycle lands in the dead queue.
				if (mv_vld_q) begin
					if (lvl_q[camq_pkg::Q_DEAD] < DEPTH_L) begin
						d_we = 1'b1;
						lvl_d[camq_pkg::Q_DEAD] = lvl_q[camq_pkg::Q_DEAD] + LW'(1);
					end else begin
						ovf_d = 1'b1;
					end
				end
				if (mv_cnt_q != '0) begin
					head_d[camq_pkg::Q_SENT] = inc(head_q[camq_pkg::Q_SENT]);
					lvl_d[camq_pkg::Q_SENT]  = lvl_q[camq_pkg::Q_SENT] - LW'(1);
					mv_cnt_d = mv_cnt_q - LW'(1);
					mv_vld_d = 1'b1;
				end else begin
					mv_vld_d = 1'b0;
					if (!mv_vld_q) begin
						state_d = camq_pkg::ST_RESP;
					end
				end
			end

			camq_pkg::ST_EMIT_START: begin
				em_vld_d  = 1'b0;
				em_done_d = 1'b0;
				if (op_q == camq_pkg::OP_DRAIN) begin
					fin_d[camq_pkg::Q_SEND] = lvl_q[camq_pkg::Q_SEND];
					fin_d[camq_pkg::Q_SENT] = lvl_q[camq_pkg::Q_SENT];
					fin_d[camq_pkg::Q_DEAD] = lvl_q[camq_pkg::Q_DEAD] - LW'(drain_n);
					q_d      = camq_pkg::Q_DEAD;
					em_cnt_d = LW'(drain_n);
					state_d  = (drain_n == '0) ? camq_pkg::ST_RESP : camq_pkg::ST_EMIT;
				end else begin
					fin_d[camq_pkg::Q_SEND] = '0;
					fin_d[camq_pkg::Q_SENT] = '0;
					fin_d[camq_pkg::Q_DEAD] = '0;
					q_d      = camq_pkg::Q_SEND;
					em_cnt_d = lvl_q[camq_pkg::Q_SEND];
					if (lvl_q[camq_pkg::Q_SEND] == '0 && lvl_q[camq_pkg::Q_SENT] == '0 &&
						lvl_q[camq_pkg::Q_DEAD] == '0) begin
						state_d = camq_pkg::ST_RESP;
					end else begin
						state_d = camq_pkg::ST_EMIT;
					end
				end
			end

			camq_pkg::ST_EMIT: begin
				if (em_vld_q) begin
					res_stb_d   = 1'b1;
					valid_res_d = 1'b1;
					case (em_from_q)
						camq_pkg::Q_SEND: out_tag_d = s_rdata[TAG_BITS-1:0];
						camq_pkg::Q_SENT: out_tag_d = t_rdata;
						default:          out_tag_d = d_rdata;
					endcase
					from_queue_d = em_from_q;
					found_o_d    = 1'b0;
					count_o_d    = '0;
					overflow_d   = 1'b0;
					last_d       = em_last_q;
					send_lvl_o_d = camq_pkg::LEVEL_W'(fin_q[camq_pkg::Q_SEND]);
					sent_lvl_o_d = camq_pkg::LEVEL_W'(fin_q[camq_pkg::Q_SENT]);
					dead_lvl_o_d = camq_pkg::LEVEL_W'(fin_q[camq_pkg::Q_DEAD]);
					if (em_last_q) begin
						state_d = camq_pkg::ST_IDLE;
					end
				end
				if (em_done_q) begin
					em_vld_d = 1'b0;
				end else if (em_cnt_q != '0) begin
					case (q_q)
						camq_pkg::Q_SEND: s_raddr = head_q[camq_pkg::Q_SEND];
						camq_pkg::Q_SENT: t_raddr = head_q[camq_pkg::Q_SENT];
						default:          d_raddr = head_q[camq_pkg::Q_DEAD];
					endcase
					head_d[q_q] = inc(head_q[q_q]);
					lvl_d[q_q]  = lvl_q[q_q] - LW'(1);
					em_cnt_d    = em_cnt_q - LW'(1);
					em_vld_d    = 1'b1;
					em_from_d   = q_q;
					em_last_d   = is_last;
					em_done_d   = is_last;
				end else begin
					em_vld_d = 1'b0;
					q_d      = q_next;
					em_cnt_d = lvl_q[q_next];
				end
			end

			camq_pkg::ST_RESP: begin
				res_stb_d    = 1'b1;
				valid_res_d  = rvalid_q;
				out_tag_d    = rtag_q;
				from_queue_d = rfrom_q;
				found_o_d    = found_q;
				count_o_d    = count_q;
				overflow_d   = ovf_q;
				last_d       = 1'b1;
				send_lvl_o_d = camq_pkg::LEVEL_W'(lvl_q[camq_pkg::Q_SEND]);
				sent_lvl_o_d = camq_pkg::LEVEL_W'(lvl_q[camq_pkg::Q_SENT]);
				dead_lvl_o_d = camq_pkg::LEVEL_W'(lvl_q[camq_pkg::Q_DEAD]);
				state_d      = camq_pkg::ST_IDLE;
			end

			default: state_d = camq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= camq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: pointers, levels and the sequencer's valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= '0;
				lvl_q[i]  <= '0;
			end
			cmp_vld_q <= 1'b0;
			mv_vld_q  <= 1'b0;
			em_vld_q  <= 1'b0;
			em_done_q <= 1'b0;
			res_stb_q <= 1'b0;
		end else begin
			head_q    <= head_d;
			lvl_q     <= lvl_d;
			cmp_vld_q <= cmp_vld_d;
			mv_vld_q  <= mv_vld_d;
			em_vld_q  <= em_vld_d;
			em_done_q <= em_done_d;
			res_stb_q <= res_stb_d;
		end
	end

	// Payload and counters that are always loaded before use.
	always_ff @(posedge clk) begin
		fin_q        <= fin_d;
		op_q         <= op_d;
		tag_q        <= tag_d;
		need_q       <= need_d;
		limit_q      <= limit_d;
		ovf_q        <= ovf_d;
		rvalid_q     <= rvalid_d;
		rtag_q       <= rtag_d;
		rfrom_q      <= rfrom_d;
		found_q      <= found_d;
		count_q      <= count_d;
		idx_q        <= idx_d;
		cmp_idx_q    <= cmp_idx_d;
		mv_cnt_q     <= mv_cnt_d;
		q_q          <= q_d;
		em_cnt_q     <= em_cnt_d;
		em_last_q    <= em_last_d;
		em_from_q    <= em_from_d;
		valid_res_q  <= valid_res_d;
		out_tag_q    <= out_tag_d;
		from_queue_q <= from_queue_d;
		found_o_q    <= found_o_d;
		count_o_q    <= count_o_d;
		overflow_q   <= overflow_d;
		last_q       <= last_d;
		send_lvl_o_q <= send_lvl_o_d;
		sent_lvl_o_q <= sent_lvl_o_d;
		dead_lvl_o_q <= dead_lvl_o_d;
	end

	assign busy       = (state_q != camq_pkg::ST_IDLE);
	assign res_stb    = res_stb_q;
	assign valid_res  = valid_res_q;
	assign out_tag    = out_tag_q;
	assign from_queue = from_queue_q;
	assign found      = found_o_q;
	assign count      = count_o_q;
	assign overflow   = overflow_q;
	assign last       = last_q;
	assign send_level = send_lvl_o_q;
	assign sent_level = sent_lvl_o_q;
	assign dead_level = dead_lvl_o_q;

endmodule

// File: hw/rtl/camq_checker.sv
// Port-level checker of the cumulative-ack message queue and its bind.
module camq_checker #(
	parameter int TAG_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [camq_pkg::OP_W-1:0]    op,
	input logic [TAG_BITS-1:0]          msg_tag,
	input logic                         needs_ack,
	input logic [camq_pkg::LIMIT_W-1:0] drain_limit,
	input logic                         res_stb,
	input logic                         valid_res,
	input logic [TAG_BITS-1:0]          out_tag,
	input logic [camq_pkg::FROM_W-1:0]  from_queue,
	input logic                         found,
	input logic [camq_pkg::COUNT_W-1:0] count,
	input logic                         overflow,
	input logic                         last,
	input logic [camq_pkg::LEVEL_W-1:0] send_level,
	input logic [camq_pkg::LEVEL_W-1:0] sent_level,
	input logic [camq_pkg::LEVEL_W-1:0] dead_level
);

	// An accepted transaction keeps the block busy at least into the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted transaction");

	// The block only goes idle as it presents the final result of a transaction.
	a_idle_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> res_stb && last)
		else $error("busy fell without a final result");

	// More results are due while a non-final result is shown.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && !last |-> busy && valid_res)
		else $error("non-final result while idle or without a tag");

	// A hit always acknowledges at least one entry, a miss none.
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb |-> (found == (count != '0)))
		else $error("found and count disagree");

	// Results without a tag carry zero tag and source queue.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && !valid_res |-> out_tag == '0 && from_queue == '0)
		else $error("empty result carries tag data");

endmodule

bind cumulative_ack_message_queue_unit camq_checker #(.TAG_BITS(TAG_BITS)) u_camq_checker (.*);

// File: bench/camq_bench_pkg.sv
`timescale 1ns / 100ps
// Shadow copy of the three tag queues that predicts and checks the unit's results.
package camq_bench_pkg;
	import camq_pkg::*;

	localparam int DEPTH = 16;
	localparam int TAG_W = 16;

	// Codes that the unit has no operation for; it must answer them with an empty result.
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic               valid_res;
		logic [TAG_W-1:0]   out_tag;
		logic [FROM_W-1:0]  from_queue;
		logic               found;
		logic [COUNT_W-1:0] count;
		logic               overflow;
		logic               last;
		logic [LEVEL_W-1:0] send_level;
		logic [LEVEL_W-1:0] sent_level;
		logic [LEVEL_W-1:0] dead_level;
	} outcome_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             needs_ack;
	} send_entry_t;

	class tag_queue_shadow;
		send_entry_t      send_q[$];
		logic [TAG_W-1:0] sent_q[$];
		logic [TAG_W-1:0] dead_q[$];
		outcome_t         awaited[$];
		int               errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int sent_depth();
			return sent_q.size();
		endfunction

		function logic [TAG_W-1:0] sent_tag(int idx);
			return sent_q[idx];
		endfunction

		function outcome_t emitted(logic [TAG_W-1:0] tag, qsel_t src);
			outcome_t r;
			r = '0;
			r.valid_res = 1'b1;
			r.out_tag = tag;
			r.from_queue = src;
			return r;
		endfunction

		// Applies one accepted transaction to the shadow queues and queues up its results.
		function void note_transaction(logic [OP_W-1:0] kind, logic [TAG_W-1:0] tag,
				logic need, logic [LIMIT_W-1:0] limit);
			outcome_t         step[$];
			outcome_t         r;
			send_entry_t      head;
			logic [TAG_W-1:0] t;
			int               run;
			int               done;
			r = '0;
			case (kind)
			OP_ENQ: begin
				if (send_q.size() < DEPTH) send_q.push_back({tag, need});
				else r.overflow = 1'b1;
				step.push_back(r);
			end
			OP_SEND: begin
				if (send_q.size() != 0) begin
					head = send_q.pop_front();
					r = emitted(head.tag, Q_SEND);
					if (head.needs_ack) begin
						if (sent_q.size() < DEPTH) sent_q.push_back(head.tag);
						else r.overflow = 1'b1;
					end
				end
				step.push_back(r);
			end
			OP_ACK, OP_NACK: begin
				// The first matching entry ends the run; everything older goes with it.
				run = 0;
				foreach (sent_q[i]) begin
					if (run == 0 && sent_q[i] == tag) run = i + 1;
				end
				r.found = (run != 0);
				r.count = run[COUNT_W-1:0];
				repeat (run) begin
					t = sent_q.pop_front();
					if (kind == OP_NACK) begin
						if (dead_q.size() < DEPTH) dead_q.push_back(t);
						else r.overflow = 1'b1;
					end
				end
				step.push_back(r);
			end
			OP_DRAIN: begin
				done = 0;
				while (dead_q.size() != 0 && (limit == 0 || done < limit)) begin
					step.push_back(emitted(dead_q.pop_front(), Q_DEAD));
					done++;
				end
				if (step.size() == 0) step.push_back(r);
			end
			OP_FLUSH: begin
				while (send_q.size() != 0) begin
					head = send_q.pop_front();
					step.push_back(emitted(head.tag, Q_SEND));
				end
				while (sent_q.size() != 0) step.push_back(emitted(sent_q.pop_front(), Q_SENT));
				while (dead_q.size() != 0) step.push_back(emitted(dead_q.pop_front(), Q_DEAD));
				if (step.size() == 0) step.push_back(r);
			end
			default: step.push_back(r);
			endcase
			foreach (step[k]) begin
				step[k].last = (k == step.size() - 1);
				step[k].send_level = send_q.size();
				step[k].sent_level = sent_q.size();
				step[k].dead_level = dead_q.size();
				awaited.push_back(step[k]);
			end
		endfunction

		function void match_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (awaited.size() == 0) begin
				$error("result with no transaction outstanding, out_tag 0x%0h", got.out_tag);
				errors++;
				return;
			end
			want = awaited.pop_front();
			match_field("valid_res", want.valid_res, got.valid_res);
			match_field("out_tag", want.out_tag, got.out_tag);
			match_field("from_queue", want.from_queue, got.from_queue);
			match_field("found", want.found, got.found);
			match_field("count", want.count, got.count);
			match_field("overflow", want.overflow, got.overflow);
			match_field("last", want.last, got.last);
			match_field("send_level", want.send_level, got.send_level);
			match_field("sent_level", want.sent_level, got.sent_level);
			match_field("dead_level", want.dead_level, got.dead_level);
		endfunction
	endclass

endpackage

// File: bench/cumulative_ack_message_queue_unit_test.sv
`timescale 1ns / 100ps
// Directed and random test of the cumulative-ack message queue unit.
module cumulative_ack_message_queue_unit_test;
	import camq_pkg::*;
	import camq_bench_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RANDOM_ITEMS   = 130;
	// A flush of three full queues is the longest transaction.
	localparam int SETTLE_CYCLES  = 64;
	// Longest quiet stretch a correct run can show: a full nack, a sender gap, or the
	// settle time at the end, with a wide margin on top.
	localparam int WATCHDOG_LIMIT = 500;

	// Traffic mixes for the random segments. Fill builds the queues up toward their
	// overflow points, retire empties them through ack, nack and drain, mixed does a
	// bit of everything, and noise throws arbitrary codes and tags at the unit.
	typedef enum int {
		MIX_FILL,
		MIX_MIXED,
		MIX_RETIRE,
		MIX_NOISE
	} mix_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic [OP_W-1:0]      op          = '0;
	logic [TAG_W-1:0]     msg_tag     = '0;
	logic                 needs_ack   = 1'b0;
	logic [LIMIT_W-1:0]   drain_limit = '0;
	logic                 busy;
	logic                 res_stb;
	logic                 valid_res;
	logic [TAG_W-1:0]     out_tag;
	logic [FROM_W-1:0]    from_queue;
	logic                 found;
	logic [COUNT_W-1:0]   count;
	logic                 overflow;
	logic                 last;
	logic [LEVEL_W-1:0]   send_level;
	logic [LEVEL_W-1:0]   sent_level;
	logic [LEVEL_W-1:0]   dead_level;

	tag_queue_shadow shadow;
	int              quiet_cycles = 0;

	cumulative_ack_message_queue_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.msg_tag     (msg_tag),
		.needs_ack   (needs_ack),
		.drain_limit (drain_limit),
		.res_stb     (res_stb),
		.valid_res   (valid_res),
		.out_tag     (out_tag),
		.from_queue  (from_queue),
		.found       (found),
		.count       (count),
		.overflow    (overflow),
		.last        (last),
		.send_level  (send_level),
		.sent_level  (sent_level),
		.dead_level  (dead_level)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Results are shown for one cycle only and cannot be held off, so every strobe is
	// taken at the rising edge that closes its cycle and checked against the oldest
	// expectation right away.
	always @(posedge clk) begin
		if (arst_n && res_stb) begin
			shadow.check_result({valid_res, out_tag, from_queue, found, count, overflow, last,
				send_level, sent_level, dead_level});
		end
	end

	// The watchdog only counts cycles in which neither a transaction nor a result moves,
	// so a long but healthy run never trips it.
	always @(posedge clk) begin
		if (!arst_n || res_stb || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("cumulative_ack_message_queue_unit_test: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Presents one transaction from a falling edge and holds it until the unit takes it.
	// Start is left high on return, so a following call keeps the sender streaming
	// without a gap; the shadow model learns of the transaction at its accepting edge.
	task automatic issue_item(input logic [OP_W-1:0] kind, input logic [TAG_W-1:0] tag,
			input logic need, input logic [LIMIT_W-1:0] limit);
		start = 1'b1;
		op = kind;
		msg_tag = tag;
		needs_ack = need;
		drain_limit = limit;
		@(posedge clk);
		while (busy) @(posedge clk);
		shadow.note_transaction(kind, tag, need, limit);
		@(negedge clk);
	endtask

	// Sender gap: start is low and the payload ports carry junk that must be ignored.
	task automatic idle_for(input int cycles);
		start = 1'b0;
		repeat (cycles) begin
			op = $urandom;
			msg_tag = $urandom;
			needs_ack = $urandom;
			drain_limit = $urandom;
			@(negedge clk);
		end
	endtask

	// Holds the sender back until every result that was predicted has come out.
	task automatic wait_until_drained();
		start = 1'b0;
		while (shadow.pending() != 0) @(negedge clk);
	endtask

	// Tags lean toward the extremes and toward a small pool, so duplicates appear in
	// the sent queue and the cumulative search has to stop at the first hit.
	function automatic logic [TAG_W-1:0] random_tag();
		case ($urandom_range(0, 3))
		0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		1:       return $urandom_range(0, 7);
		default: return $urandom;
		endcase
	endfunction

	task automatic random_item(input mix_t mix);
		logic [OP_W-1:0]    kind;
		logic [TAG_W-1:0]   tag;
		logic               need;
		logic [LIMIT_W-1:0] limit;
		int                 w;
		w = $urandom_range(0, 99);
		case (mix)
		MIX_FILL: begin
			kind = (w < 55) ? OP_ENQ : (w < 95) ? OP_SEND : OP_NACK;
		end
		MIX_MIXED: begin
			if (w < 25) kind = OP_ENQ;
			else if (w < 50) kind = OP_SEND;
			else if (w < 65) kind = OP_ACK;
			else if (w < 80) kind = OP_NACK;
			else if (w < 92) kind = OP_DRAIN;
			else if (w < 97) kind = OP_FLUSH;
			else kind = (w[0]) ? OP_RSVD7 : OP_RSVD6;
		end
		MIX_RETIRE: begin
			if (w < 10) kind = OP_ENQ;
			else if (w < 25) kind = OP_SEND;
			else if (w < 50) kind = OP_ACK;
			else if (w < 75) kind = OP_NACK;
			else kind = OP_DRAIN;
		end
		default: kind = $urandom_range(0, 7);
		endcase
		need = (mix == MIX_FILL) ? ($urandom_range(0, 9) != 0) : $urandom_range(0, 1);
		limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
		tag = random_tag();
		// Most acks and nacks name a tag that is really waiting, otherwise the search
		// would almost never hit. While filling, a nack takes the whole sent queue so
		// that the dead queue climbs toward its overflow point.
		if ((kind == OP_ACK || kind == OP_NACK) && shadow.sent_depth() != 0) begin
			if (mix == MIX_FILL) tag = shadow.sent_tag(shadow.sent_depth() - 1);
			else if ($urandom_range(0, 4) != 0)
				tag = shadow.sent_tag($urandom_range(0, shadow.sent_depth() - 1));
		end
		issue_item(kind, tag, need, limit);
	endtask

	initial begin
		int   issued;
		int   segment_len;
		int   burst_left;
		int   w;
		bit   steady;
		mix_t mix;
		shadow = new();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty queues first: every emitting operation must answer with an empty result,
		// and a search of an empty sent queue finds nothing. The two spare codes go along.
		issue_item(OP_SEND, 16'h0000, 1'b0, 5'd0);
		issue_item(OP_DRAIN, 16'h0000, 1'b0, 5'd0);
		issue_item(OP_FLUSH, 16'hFFFF, 1'b1, 5'd31);
		issue_item(OP_ACK, 16'h0000, 1'b0, 5'd0);
		issue_item(OP_NACK, 16'hFFFF, 1'b1, 5'd16);
		issue_item(OP_RSVD6, 16'hFFFF, 1'b1, 5'd31);
		issue_item(OP_RSVD7, 16'h0000, 1'b0, 5'd0);

		// Extreme tags through the send queue; the message without the ack flag must not
		// reach the sent queue.
		issue_item(OP_ENQ, 16'hFFFF, 1'b1, 5'd0);
		issue_item(OP_ENQ, 16'h0000, 1'b1, 5'd0);
		issue_item(OP_ENQ, 16'h5A5A, 1'b0, 5'd0);
		issue_item(OP_ENQ, 16'hA5A5, 1'b1, 5'd0);
		repeat (4) issue_item(OP_SEND, 16'h0000, 1'b0, 5'd0);

		// An absent tag changes nothing, a nack in the middle retires the older entries
		// with it, and an ack of the last entry empties the sent queue.
		issue_item(OP_ACK, 16'h1234, 1'b0, 5'd0);
		issue_item(OP_NACK, 16'h0000, 1'b0, 5'd0);
		issue_item(OP_ACK, 16'hA5A5, 1'b0, 5'd0);

		// Drain with a limit of one, then with a limit above the dead level.
		issue_item(OP_DRAIN, 16'h0000, 1'b0, 5'd1);
		issue_item(OP_DRAIN, 16'h0000, 1'b0, 5'd16);

		// Put one entry in each queue and flush them all in send, sent, dead order.
		issue_item(OP_ENQ, 16'h1111, 1'b1, 5'd0);
		issue_item(OP_ENQ, 16'h2222, 1'b1, 5'd0);
		issue_item(OP_ENQ, 16'h3333, 1'b0, 5'd0);
		issue_item(OP_SEND, 16'h0000, 1'b0, 5'd0);
		issue_item(OP_SEND, 16'h0000, 1'b0, 5'd0);
		issue_item(OP_NACK, 16'h1111, 1'b0, 5'd0);
		issue_item(OP_FLUSH, 16'h0000, 1'b0, 5'd0);

		// The sender holds off once here until the unit has answered everything.
		wait_until_drained();

		// Random segments, each with one traffic mix. Within a segment the sender works
		// in bursts with random gaps, except in steady segments where it never pauses.
		// Now and then a segment starts only after the unit has fully caught up.
		issued = 0;
		burst_left = $urandom_range(1, 8);
		while (issued < RANDOM_ITEMS) begin
			w = $urandom_range(0, 99);
			if (w < 35) mix = MIX_FILL;
			else if (w < 70) mix = MIX_MIXED;
			else if (w < 90) mix = MIX_RETIRE;
			else mix = MIX_NOISE;
			segment_len = $urandom_range(5, 15);
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0) wait_until_drained();
			repeat (segment_len) begin
				random_item(mix);
				issued++;
				burst_left--;
				if (!steady && burst_left <= 0) begin
					idle_for($urandom_range(1, 6));
					burst_left = $urandom_range(1, 8);
				end
			end
		end

		// Wait for the last predicted result, then watch a while longer for strays.
		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shadow.errors == 0) begin
			$display("cumulative_ack_message_queue_unit_test: clean");
		end else begin
			$display("cumulative_ack_message_queue_unit_test: errors");
		end
		$finish;
	end

endmodule
